/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define HMF_ASSERT_IMPLIES(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("assertion failed");

// invariant checked on every clock edge outside reset
`define HMF_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

`endif

/* rtl/hmf_pkg.sv */
`default_nettype none
package hmf_pkg;

   localparam int MAX_RADIUS_DEF = 7;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT     = 4096;
   localparam int QUEUE_DEPTH    = 2;

   localparam int PIX_W      = 8;
   localparam int RADIUS_W   = 3;
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 13;
   localparam int OUT_COL_W  = 10;
   localparam int ROW_W      = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // widest internal fields over the whole parameter range
   localparam int COL_MAX_W  = 12;
   localparam int SLOT_MAX_W = 5;
   localparam int RAD_MAX_W  = 4;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 3'd1;
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [RADIUS_W-1:0] radius;
      logic [WIDTH_W-1:0]  image_width;
      logic [HEIGHT_W-1:0] image_height;
   } cfg_type;

   typedef struct packed {
      logic [PIX_W-1:0]      pixel;
      logic [COL_MAX_W-1:0]  col;
      logic [SLOT_MAX_W-1:0] slot;
      logic [RAD_MAX_W-1:0]  radius;
      logic                  emit;
      logic [OUT_COL_W-1:0]  cx;
      logic [ROW_W-1:0]      cy;
      logic                  last;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_WRITE,
      BK_SCAN,
      BK_TALLY,
      BK_DONE
   } back_state_type;

endpackage
`default_nettype wire

/* rtl/hmf_req_if.sv */
`default_nettype none
interface hmf_req_if;
   logic                    valid;
   logic                    ready;
   logic [hmf_pkg::PIX_W-1:0] pixel_value;
   logic                    frame_start;

   modport source (output valid, output pixel_value, output frame_start, input ready);
   modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface
`default_nettype wire

/* rtl/hmf_rsp_if.sv */
`default_nettype none
interface hmf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [hmf_pkg::PIX_W-1:0]     median_value;
   logic [hmf_pkg::OUT_COL_W-1:0] centre_column;
   logic [hmf_pkg::ROW_W-1:0]     centre_row;
   logic                        frame_last;

   modport source (output valid, output median_value, output centre_column,
                   output centre_row, output frame_last, input ready);
   modport sink   (input valid, input median_value, input centre_column,
                   input centre_row, input frame_last, output ready);
endinterface
`default_nettype wire

/* rtl/histogram_median_filter_core.sv */
// square-window median filter for 8-bit grey pixels in raster order
// req_chan: valid/ready transfer of pixel_value and frame_start
// rsp_chan: valid/ready transfer of median_value, centre_column, centre_row
//   and frame_last, one per centre whose window lies inside the image
// csr: write enable, index (0 radius, 1 image width, 2 image height), data
// the front tracks column and row and classifies each pixel; a two-entry
// queue feeds the back, which writes the line store and finds the median
// by an 8-pass bitwise search, reading one window pixel a cycle
// a pixel with no result passes the back in the idle and write states;
// one with a result then runs the scan and tally states for each pass and
// ends in the done state, its time set by the single line store read port
// the front keeps taking pixels while the queue has room
// reset clears position, control state and sets radius 1, 640 x 480; the
// line store is not cleared
// a stalled receiver holds the result in the output register; the back
// then waits and the queue fills before req_chan.ready drops
`default_nettype none
module histogram_median_filter_core #(
   parameter int MAX_RADIUS = hmf_pkg::MAX_RADIUS_DEF,
   parameter int MAX_WIDTH  = hmf_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   hmf_req_if.sink                             req_chan,
   hmf_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_write_enable,
   input  wire logic [hmf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [hmf_pkg::CSR_DATA_W-1:0] csr_write_data
);
   hmf_pkg::cfg_type cfg_ff;
   hmf_pkg::job_type push_job, head_job;
   logic             push, pop, full, empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radius       <= hmf_pkg::RADIUS_RESET;
         cfg_ff.image_width  <= hmf_pkg::WIDTH_RESET;
         cfg_ff.image_height <= hmf_pkg::HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            hmf_pkg::CSR_RADIUS: cfg_ff.radius <= csr_write_data[hmf_pkg::RADIUS_W-1:0];
            hmf_pkg::CSR_WIDTH:  cfg_ff.image_width <= csr_write_data[hmf_pkg::WIDTH_W-1:0];
            hmf_pkg::CSR_HEIGHT: cfg_ff.image_height <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   hmf_front #(.MAX_RADIUS(MAX_RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_chan (req_chan),
      .full     (full),
      .push     (push),
      .job      (push_job)
   );

   hmf_queue #(.DEPTH(hmf_pkg::QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .pop       (pop),
      .head      (head_job),
      .full      (full),
      .empty     (empty)
   );

   hmf_back #(.MAX_RADIUS(MAX_RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head_job),
      .empty    (empty),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );
endmodule
`default_nettype wire

/* rtl/hmf_front.sv */
`default_nettype none
module hmf_front #(
   parameter int MAX_RADIUS = hmf_pkg::MAX_RADIUS_DEF,
   parameter int MAX_WIDTH  = hmf_pkg::MAX_WIDTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire hmf_pkg::cfg_type cfg,
   hmf_req_if.sink               req_chan,
   input  wire logic             full,
   output logic                  push,
   output hmf_pkg::job_type      job
);
   localparam int CW          = $clog2(MAX_WIDTH);
   localparam int STORE_LINES = 2 * MAX_RADIUS + 1;
   localparam int SW          = $clog2(STORE_LINES);
   localparam int RW          = $clog2(MAX_RADIUS + 1);
   localparam int HW          = hmf_pkg::HEIGHT_W;

   logic [CW-1:0]             col_ff, col_in;
   logic [hmf_pkg::ROW_W-1:0] row_ff, row_in;
   logic [SW-1:0]             slot_ff, slot_in;

   logic [RW-1:0] r_eff;
   logic [CW:0]   w_eff;
   logic [HW-1:0] h_eff;
   logic [CW-1:0] c0;
   logic [HW-1:0] r0, nr;
   logic [SW-1:0] s0;
   logic [CW:0]   nc;
   logic [31:0]   cx_full, cy_full;

   // effective configuration
   always_comb begin
      r_eff = (int'(cfg.radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(cfg.radius);
      if (cfg.image_width == '0) begin
         w_eff = (CW+1)'(1);
      end else if (int'(cfg.image_width) > MAX_WIDTH) begin
         w_eff = (CW+1)'(MAX_WIDTH);
      end else begin
         w_eff = (CW+1)'(cfg.image_width);
      end
      if (cfg.image_height == '0) begin
         h_eff = HW'(1);
      end else if (int'(cfg.image_height) > hmf_pkg::MAX_HEIGHT) begin
         h_eff = HW'(hmf_pkg::MAX_HEIGHT);
      end else begin
         h_eff = cfg.image_height;
      end
   end

   assign push           = req_chan.valid && !full;
   assign req_chan.ready = !full;

   // position of this pixel and the one after it
   always_comb begin
      c0 = col_ff;
      r0 = {1'b0, row_ff};
      s0 = slot_ff;
      if (req_chan.frame_start) begin
         c0 = '0;
         r0 = '0;
         s0 = '0;
      end
      if ({1'b0, c0} >= w_eff) begin
         c0 = '0;
         r0 = r0 + HW'(1);
         s0 = (int'(s0) == STORE_LINES - 1) ? '0 : s0 + SW'(1);
      end
      if (r0 >= h_eff) begin
         r0 = '0;
         s0 = '0;
      end

      cx_full = 32'(c0) - 32'(r_eff);
      cy_full = 32'(r0) - 32'(r_eff);

      job.pixel  = req_chan.pixel_value;
      job.col    = hmf_pkg::COL_MAX_W'(c0);
      job.slot   = hmf_pkg::SLOT_MAX_W'(s0);
      job.radius = hmf_pkg::RAD_MAX_W'(r_eff);
      job.emit   = (32'(c0) >= 2 * 32'(r_eff)) && (32'(r0) >= 2 * 32'(r_eff));
      job.cx     = cx_full[hmf_pkg::OUT_COL_W-1:0];
      job.cy     = cy_full[hmf_pkg::ROW_W-1:0];
      job.last   = ({1'b0, c0} == w_eff - (CW+1)'(1)) && (r0 == h_eff - HW'(1));

      nc      = {1'b0, c0} + (CW+1)'(1);
      nr      = r0 + HW'(1);
      col_in  = nc[CW-1:0];
      row_in  = r0[hmf_pkg::ROW_W-1:0];
      slot_in = s0;
      if (nc >= w_eff) begin
         col_in = '0;
         if (nr >= h_eff) begin
            row_in  = '0;
            slot_in = '0;
         end else begin
            row_in  = nr[hmf_pkg::ROW_W-1:0];
            slot_in = (int'(s0) == STORE_LINES - 1) ? '0 : s0 + SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else if (push) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/hmf_queue.sv */
`default_nettype none
`include "assert_macros.svh"
module hmf_queue #(
   parameter int DEPTH = hmf_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire hmf_pkg::job_type push_data,
   input  wire logic             pop,
   output hmf_pkg::job_type      head,
   output logic                  full,
   output logic                  empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   hmf_pkg::job_type entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0]    count_ff;

   assign full  = (int'(count_ff) == DEPTH);
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (int'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (int'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + NW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - NW'(1);
         end
      end
   end

   `HMF_ASSERT_IMPLIES(a_pop_not_empty, clock, reset, pop, count_ff != '0)
   `HMF_ASSERT_IMPLIES(a_push_not_full, clock, reset, push, int'(count_ff) < DEPTH)
endmodule
`default_nettype wire

/* rtl/hmf_back.sv */
`default_nettype none
`include "assert_macros.svh"
module hmf_back #(
   parameter int MAX_RADIUS = hmf_pkg::MAX_RADIUS_DEF,
   parameter int MAX_WIDTH  = hmf_pkg::MAX_WIDTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire hmf_pkg::job_type head,
   input  wire logic             empty,
   output logic                  pop,
   hmf_rsp_if.source             rsp_chan
);
   localparam int CW          = $clog2(MAX_WIDTH);
   localparam int STORE_LINES = 2 * MAX_RADIUS + 1;
   localparam int SW          = $clog2(STORE_LINES);
   localparam int AW          = SW + CW;
   localparam int DW          = $clog2(STORE_LINES + 1);
   localparam int NW          = $clog2(STORE_LINES * STORE_LINES + 1);
   localparam int PX          = hmf_pkg::PIX_W;

   hmf_pkg::back_state_type state_ff, state_in;
   hmf_pkg::job_type        job_ff, job_in;

   logic [PX-1:0] mem [1 << AW];
   logic [PX-1:0] rd_data_ff;
   logic          rd_valid_ff, rd_valid_in;
   logic          mem_we;

   logic [2:0]    bit_ff, bit_in;
   logic [PX-1:0] prefix_ff, prefix_in;
   logic [NW-1:0] cnt_ff, cnt_in, total;
   logic [NW-1:0] half_ff, half_in;
   logic [DW-1:0] side_ff, side_in;
   logic [DW-1:0] i_ff, i_in, j_ff, j_in;
   logic [SW-1:0] rslot_ff, rslot_in;
   logic [CW-1:0] rcol_ff, rcol_in;
   logic [PX-1:0] mask, thresh;
   logic          hit, load_out;
   logic [2*DW-1:0] sq;

   logic [PX-1:0]                 out_median_ff;
   logic [hmf_pkg::OUT_COL_W-1:0] out_col_ff;
   logic [hmf_pkg::ROW_W-1:0]     out_row_ff;
   logic                          out_last_ff, out_valid_ff;

   // line store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[{job_ff.slot[SW-1:0], job_ff.col[CW-1:0]}] <= job_ff.pixel;
      end
      rd_data_ff <= mem[{rslot_ff, rcol_ff}];
   end

   assign mask   = PX'((9'd1 << bit_ff) - 9'd1);
   assign thresh = prefix_ff | mask;
   assign hit    = rd_valid_ff && (rd_data_ff <= thresh);
   assign total  = cnt_ff + NW'(hit);

   always_comb begin
      state_in    = state_ff;
      job_in      = job_ff;
      bit_in      = bit_ff;
      prefix_in   = prefix_ff;
      cnt_in      = cnt_ff;
      half_in     = half_ff;
      side_in     = side_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      rslot_in    = rslot_ff;
      rcol_in     = rcol_ff;
      rd_valid_in = 1'b0;
      mem_we      = 1'b0;
      pop         = 1'b0;
      load_out    = 1'b0;
      sq          = '0;
      case (state_ff)
         hmf_pkg::BK_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               job_in   = head;
               side_in  = DW'({head.radius, 1'b1});
               sq       = (2*DW)'(side_in) * (2*DW)'(side_in);
               half_in  = NW'(sq >> 1);
               state_in = hmf_pkg::BK_WRITE;
            end
         end
         hmf_pkg::BK_WRITE: begin
            mem_we = 1'b1;
            if (job_ff.emit) begin
               bit_in    = 3'd7;
               prefix_in = '0;
               cnt_in    = '0;
               i_in      = '0;
               j_in      = '0;
               rslot_in  = job_ff.slot[SW-1:0];
               rcol_in   = job_ff.col[CW-1:0];
               state_in  = hmf_pkg::BK_SCAN;
            end else begin
               state_in = hmf_pkg::BK_IDLE;
            end
         end
         hmf_pkg::BK_SCAN: begin
            rd_valid_in = 1'b1;
            cnt_in      = total;
            if (j_ff == side_ff - DW'(1)) begin
               j_in    = '0;
               rcol_in = job_ff.col[CW-1:0];
               if (i_ff == side_ff - DW'(1)) begin
                  state_in = hmf_pkg::BK_TALLY;
               end else begin
                  i_in     = i_ff + DW'(1);
                  rslot_in = (rslot_ff == '0) ? SW'(STORE_LINES - 1) : rslot_ff - SW'(1);
               end
            end else begin
               j_in    = j_ff + DW'(1);
               rcol_in = rcol_ff - CW'(1);
            end
         end
         hmf_pkg::BK_TALLY: begin
            if (!(total > half_ff)) begin
               prefix_in = prefix_ff | PX'(9'd1 << bit_ff);
            end
            cnt_in   = '0;
            i_in     = '0;
            j_in     = '0;
            rslot_in = job_ff.slot[SW-1:0];
            rcol_in  = job_ff.col[CW-1:0];
            if (bit_ff == '0) begin
               state_in = hmf_pkg::BK_DONE;
            end else begin
               bit_in   = bit_ff - 3'd1;
               state_in = hmf_pkg::BK_SCAN;
            end
         end
         hmf_pkg::BK_DONE: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               load_out = 1'b1;
               state_in = hmf_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = hmf_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hmf_pkg::BK_IDLE;
      end else begin
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_valid_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      bit_ff    <= bit_in;
      prefix_ff <= prefix_in;
      cnt_ff    <= cnt_in;
      half_ff   <= half_in;
      side_ff   <= side_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      rslot_ff  <= rslot_in;
      rcol_ff   <= rcol_in;
      if (load_out) begin
         out_median_ff <= prefix_ff;
         out_col_ff    <= job_ff.cx;
         out_row_ff    <= job_ff.cy;
         out_last_ff   <= job_ff.last;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.median_value  = out_median_ff;
   assign rsp_chan.centre_column = out_col_ff;
   assign rsp_chan.centre_row    = out_row_ff;
   assign rsp_chan.frame_last    = out_last_ff;

   `HMF_ASSERT_IMPLIES(a_tally_has_data, clock, reset,
      state_ff == hmf_pkg::BK_TALLY, rd_valid_ff)
   `HMF_ASSERT_IMPLIES(a_scan_in_window, clock, reset,
      state_ff == hmf_pkg::BK_SCAN, (i_ff < side_ff) && (j_ff < side_ff))
endmodule
`default_nettype wire

/* tb/sv/histogram_median_filter_core_test.sv */
module histogram_median_filter_core_test;
   localparam int PIX_W = hmf_pkg::PIX_W;
   localparam int OUT_COL_W = hmf_pkg::OUT_COL_W;
   localparam int ROW_W = hmf_pkg::ROW_W;
   localparam int CSR_DATA_W = hmf_pkg::CSR_DATA_W;
   localparam int CSR_IDX_W = hmf_pkg::CSR_IDX_W;
   localparam int RADIUS_W = hmf_pkg::RADIUS_W;
   localparam int WIDTH_W = hmf_pkg::WIDTH_W;
   localparam int HEIGHT_W = hmf_pkg::HEIGHT_W;
   localparam int MAX_WIDTH_DEF = hmf_pkg::MAX_WIDTH_DEF;
   localparam int MAX_HEIGHT = hmf_pkg::MAX_HEIGHT;
   localparam int STORE_LINES = 2 * hmf_pkg::MAX_RADIUS_DEF + 1;
   localparam int RANDOM_PIXELS = 1700;
   localparam int CALM_AFTER = 1400;
   localparam int SETTLE_CYCLES = 64;

   typedef struct packed {
      logic [PIX_W-1:0]     median;
      logic [OUT_COL_W-1:0] col;
      logic [ROW_W-1:0]     row;
      logic                 last;
   } median_result_type;

   typedef enum logic {SCRIPT_CSR, SCRIPT_PIXEL} script_kind_type;

   typedef struct packed {
      script_kind_type        kind;
      hmf_pkg::csr_index_type index;
      logic [CSR_DATA_W-1:0]  data;
      logic [PIX_W-1:0]       pixel;
      logic                   frame_start;
      logic                   typed;
      median_result_type      result;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   hmf_req_if req_chan();
   hmf_rsp_if rsp_chan();

   histogram_median_filter_core dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #1 clock = ~clock;

   // filter state as seen from outside
   logic [PIX_W-1:0] pixel_lines [STORE_LINES][MAX_WIDTH_DEF];
   int unsigned pos_col;
   int unsigned pos_row;
   logic [RADIUS_W-1:0] cfg_radius;
   logic [WIDTH_W-1:0]  cfg_width;
   logic [HEIGHT_W-1:0] cfg_height;

   median_result_type pending_medians [$];
   median_result_type seen_median;
   median_result_type due_median;
   int fails;
   bit source_idling;
   bit sink_idling;
   int sink_hold;
   int sink_gap;

   function automatic logic [PIX_W-1:0] window_median(int unsigned r, int unsigned col,
                                                       int unsigned row);
      int hist [256];
      int unsigned side;
      int unsigned half;
      int unsigned seen;
      side = 2 * r + 1;
      half = (side * side) / 2;
      seen = 0;
      foreach (hist[v]) hist[v] = 0;
      for (int unsigned i = 0; i < side; i++) begin
         for (int unsigned j = 0; j < side; j++) begin
            hist[pixel_lines[(row - i) % STORE_LINES][(col - j) % MAX_WIDTH_DEF]]++;
         end
      end
      for (int v = 0; v < 255; v++) begin
         seen += hist[v];
         if (seen > half) return PIX_W'(v);
      end
      return 8'd255;
   endfunction

   task automatic take_pixel(input logic [PIX_W-1:0] p, input logic fs, output bit found,
                             output median_result_type res);
      int unsigned r;
      int unsigned w;
      int unsigned h;
      int unsigned col;
      int unsigned row;
      r = cfg_radius;
      w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cfg_width);
      h = (cfg_height == 0) ? 1 : ((cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height);
      found = 1'b0;
      res = '0;
      if (fs) begin
         pos_col = 0;
         pos_row = 0;
      end
      if (pos_col >= w) begin
         pos_col = 0;
         pos_row++;
      end
      if (pos_row >= h) pos_row = 0;
      col = pos_col;
      row = pos_row;
      pixel_lines[row % STORE_LINES][col % MAX_WIDTH_DEF] = p;
      if (col >= 2 * r && row >= 2 * r) begin
         found = 1'b1;
         res.median = window_median(r, col, row);
         res.col = OUT_COL_W'(col - r);
         res.row = ROW_W'(row - r);
         res.last = (col == w - 1 && row == h - 1);
      end
      pos_col = col + 1;
      if (pos_col >= w) begin
         pos_col = 0;
         pos_row = row + 1;
         if (pos_row >= h) pos_row = 0;
      end
   endtask

   task automatic offer_pixel(input logic [PIX_W-1:0] p, input logic fs, input bit typed,
                              input median_result_type typed_res);
      bit found;
      median_result_type res;
      if (source_idling && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.pixel_value <= p;
      req_chan.frame_start <= fs;
      @(negedge clock);
      while (!req_chan.ready) @(negedge clock);
      take_pixel(p, fs, found, res);
      if (typed) pending_medians.push_back(typed_res);
      else if (found) pending_medians.push_back(res);
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_medians.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input hmf_pkg::csr_index_type idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         hmf_pkg::CSR_RADIUS: cfg_radius = data[RADIUS_W-1:0];
         hmf_pkg::CSR_WIDTH:  cfg_width = data[WIDTH_W-1:0];
         hmf_pkg::CSR_HEIGHT: cfg_height = data[HEIGHT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // receiver: random stalls plus a long hold requested by the main sequence
   initial begin
      rsp_chan.ready <= 1'b0;
      sink_hold = 0;
      sink_gap = 0;
      forever begin
         @(posedge clock);
         if (sink_hold > 0) begin
            sink_hold--;
            rsp_chan.ready <= 1'b0;
         end else if (sink_gap > 0) begin
            sink_gap--;
            rsp_chan.ready <= 1'b0;
         end else if (sink_idling && $urandom_range(0, 9) == 0) begin
            sink_gap = $urandom_range(1, 14) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen_median = '{rsp_chan.median_value, rsp_chan.centre_column,
                         rsp_chan.centre_row, rsp_chan.frame_last};
         if (pending_medians.size() == 0) begin
            $error("result with none expected: median_value %0d", seen_median.median);
            fails++;
         end else begin
            due_median = pending_medians.pop_front();
            if (seen_median.median !== due_median.median) begin
               $error("median_value expected %0d actual %0d", due_median.median,
                      seen_median.median);
               fails++;
            end
            if (seen_median.col !== due_median.col) begin
               $error("centre_column expected %0d actual %0d", due_median.col,
                      seen_median.col);
               fails++;
            end
            if (seen_median.row !== due_median.row) begin
               $error("centre_row expected %0d actual %0d", due_median.row, seen_median.row);
               fails++;
            end
            if (seen_median.last !== due_median.last) begin
               $error("frame_last expected %0d actual %0d", due_median.last,
                      seen_median.last);
               fails++;
            end
         end
      end
   end

   initial begin
      #20000000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      script_row_type script [$];
      int sent;
      int phase;
      int unsigned r;
      int unsigned w;
      int unsigned h;
      int unsigned n;
      fails = 0;
      source_idling = 1'b1;
      sink_idling = 1'b1;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.pixel_value <= '0;
      req_chan.frame_start <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= hmf_pkg::CSR_RADIUS;
      csr_write_data <= '0;
      cfg_radius = hmf_pkg::RADIUS_RESET;
      cfg_width = hmf_pkg::WIDTH_RESET;
      cfg_height = hmf_pkg::HEIGHT_RESET;
      pos_col = 0;
      pos_row = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // radius 0 on a 1x1 image: pass-through, every pixel is the frame end
      script.push_back('{SCRIPT_CSR, hmf_pkg::CSR_RADIUS, 13'd0, 8'd0, 1'b0, 1'b0, '0});
      script.push_back('{SCRIPT_CSR, hmf_pkg::CSR_WIDTH, 13'd0, 8'd0, 1'b0, 1'b0, '0});
      script.push_back('{SCRIPT_CSR, hmf_pkg::CSR_HEIGHT, 13'd0, 8'd0, 1'b0, 1'b0, '0});
      script.push_back('{SCRIPT_PIXEL, hmf_pkg::CSR_RADIUS, 13'd0, 8'd0, 1'b1, 1'b1,
                         '{8'd0, 10'd0, 12'd0, 1'b1}});
      script.push_back('{SCRIPT_PIXEL, hmf_pkg::CSR_RADIUS, 13'd0, 8'd255, 1'b0, 1'b1,
                         '{8'd255, 10'd0, 12'd0, 1'b1}});
      // width clamps to the widest line
      script.push_back('{SCRIPT_CSR, hmf_pkg::CSR_WIDTH, 13'd2047, 8'd0, 1'b0, 1'b0, '0});
      script.push_back('{SCRIPT_CSR, hmf_pkg::CSR_HEIGHT, 13'd1, 8'd0, 1'b0, 1'b0, '0});
      script.push_back('{SCRIPT_PIXEL, hmf_pkg::CSR_RADIUS, 13'd0, 8'h0f, 1'b1, 1'b1,
                         '{8'h0f, 10'd0, 12'd0, 1'b0}});
      script.push_back('{SCRIPT_PIXEL, hmf_pkg::CSR_RADIUS, 13'd0, 8'hf0, 1'b0, 1'b1,
                         '{8'hf0, 10'd1, 12'd0, 1'b0}});
      // height clamps to the tallest frame
      script.push_back('{SCRIPT_CSR, hmf_pkg::CSR_WIDTH, 13'd1, 8'd0, 1'b0, 1'b0, '0});
      script.push_back('{SCRIPT_CSR, hmf_pkg::CSR_HEIGHT, 13'd8191, 8'd0, 1'b0, 1'b0, '0});
      script.push_back('{SCRIPT_PIXEL, hmf_pkg::CSR_RADIUS, 13'd0, 8'h33, 1'b1, 1'b1,
                         '{8'h33, 10'd0, 12'd0, 1'b0}});
      script.push_back('{SCRIPT_PIXEL, hmf_pkg::CSR_RADIUS, 13'd0, 8'hcc, 1'b0, 1'b1,
                         '{8'hcc, 10'd0, 12'd1, 1'b0}});
      // 3x3 windows, then the width shrinks to no more than the current column
      script.push_back('{SCRIPT_CSR, hmf_pkg::CSR_RADIUS, 13'd1, 8'd0, 1'b0, 1'b0, '0});
      script.push_back('{SCRIPT_CSR, hmf_pkg::CSR_WIDTH, 13'd5, 8'd0, 1'b0, 1'b0, '0});
      script.push_back('{SCRIPT_CSR, hmf_pkg::CSR_HEIGHT, 13'd8, 8'd0, 1'b0, 1'b0, '0});
      for (int i = 0; i < 13; i++)
         script.push_back('{SCRIPT_PIXEL, hmf_pkg::CSR_RADIUS, 13'd0, 8'($urandom), i == 0,
                            1'b0, '0});
      script.push_back('{SCRIPT_CSR, hmf_pkg::CSR_WIDTH, 13'd3, 8'd0, 1'b0, 1'b0, '0});
      for (int i = 0; i < 3; i++)
         script.push_back('{SCRIPT_PIXEL, hmf_pkg::CSR_RADIUS, 13'd0, 8'($urandom), 1'b0,
                            1'b0, '0});

      foreach (script[i]) begin
         if (script[i].kind == SCRIPT_CSR) begin
            wait_drained();
            write_csr(script[i].index, script[i].data);
         end else begin
            offer_pixel(script[i].pixel, script[i].frame_start, script[i].typed,
                        script[i].result);
         end
      end

      sent = 0;
      phase = 0;
      while (sent < RANDOM_PIXELS) begin
         if (phase == 0) begin
            r = 7;
            w = 16;
            h = 16;
         end else if (phase == 2) begin
            r = 1;
            w = 8;
            h = 8;
         end else begin
            r = $urandom_range(0, 4);
            w = $urandom_range(1, 20);
            h = $urandom_range(1, 14);
         end
         source_idling = sent < CALM_AFTER && $urandom_range(0, 3) != 0;
         sink_idling = sent < CALM_AFTER && $urandom_range(0, 3) != 0;
         wait_drained();
         write_csr(hmf_pkg::CSR_RADIUS, CSR_DATA_W'(r));
         write_csr(hmf_pkg::CSR_WIDTH, CSR_DATA_W'(w));
         write_csr(hmf_pkg::CSR_HEIGHT, CSR_DATA_W'(h));
         if (phase == 2) sink_hold = 500;
         repeat ($urandom_range(1, 3)) begin
            n = w * h;
            // some frames break off early and the next one restarts
            if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
            for (int unsigned i = 0; i < n && sent < RANDOM_PIXELS; i++) begin
               offer_pixel(8'($urandom), i == 0, 1'b0, '0);
               sent++;
            end
         end
         phase++;
      end

      source_idling = 1'b0;
      sink_idling = 1'b0;
      wait_drained();
      repeat (200) @(posedge clock);
      if (fails == 0 && pending_medians.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
